@@ rtl/lcs_pkg.sv @@
`default_nettype none

package lcs_pkg;

    // Capacity of the X symbol store and of the table row.
    localparam int MAX_LEN     = 1024;
    localparam int SYMBOL_BITS = 8;

    // Derived widths.
    localparam int ADDR_BITS = $clog2(MAX_LEN);
    localparam int CNT_BITS  = $clog2(MAX_LEN + 1);
    localparam int LEN_BITS  = 11;

    // Input item kinds.
    localparam logic KIND_X = 1'b0;
    localparam logic KIND_Y = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 store_x;
        logic                 start_y;
        logic                 step;
        logic                 emit;
        logic [ADDR_BITS-1:0] waddr;
        logic [ADDR_BITS-1:0] raddr;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_BITS-1:0] x_count;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/lcs_length_dp_unit.sv @@
`default_nettype none

// LCS length unit: length of the longest common subsequence of X and Y.
// Input channel: an item transfers at a rising edge with i_start high and
// o_busy low. An item carries i_kind (0 = X symbol, 1 = Y symbol), i_symbol
// and i_last. X symbols are stored, up to 1024; further ones are dropped
// and flagged. Each Y symbol updates one table row; the first Y symbol of
// a pair starts a fresh row.
// An X symbol never raises o_busy. A Y symbol holds o_busy high while the
// row is walked one column per cycle over the stored X symbols, through the
// row memory with one write and one read port; a Y symbol with no stored X
// never raises o_busy.
// Result channel: a Y symbol with i_last high produces one result, shown on
// o_lcs_length and o_x_overflow for exactly one cycle with o_valid high,
// in the cycle after the last busy cycle (after the transfer if X is empty).
// The receiver cannot stall; the result transfers with that cycle.
// An X symbol arriving after Y symbols abandons the pair without a result.
// Reset (synchronous, active low) empties the X store and clears the pair;
// memory contents need no clearing pass.
module lcs_length_dp_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_kind,
    input  wire logic [7:0]                   i_symbol,
    input  wire logic                         i_last,
    output logic                              o_valid,
    output logic [lcs_pkg::LEN_BITS-1:0]      o_lcs_length,
    output logic                              o_x_overflow
);

    lcs_pkg::t_cmd  cmd;
    lcs_pkg::t_stat stat;

    // Controller.
    lcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_kind),
        .i_last  (i_last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Datapath.
    lcs_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_symbol     (i_symbol),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_lcs_length (o_lcs_length),
        .o_x_overflow (o_x_overflow)
    );

endmodule

`default_nettype wire

@@ rtl/lcs_ctrl.sv @@
`default_nettype none

module lcs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_kind,
    input  wire logic          i_last,
    input  wire lcs_pkg::t_stat i_stat,
    output lcs_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state                        r_state, n_state;
    logic [lcs_pkg::ADDR_BITS-1:0] r_idx, n_idx;
    logic                          r_last, n_last;

    logic                          accept;
    logic                          row_end;
    logic [lcs_pkg::CNT_BITS-1:0]  last_col;

    assign o_busy   = (r_state == ST_RUN);
    assign accept   = i_start && !o_busy;
    assign last_col = lcs_pkg::CNT_BITS'(i_stat.x_count - 1'b1);
    assign row_end  = (r_idx == last_col[lcs_pkg::ADDR_BITS-1:0]);

    // Sequencer: one table column per cycle while a Y symbol is in work.
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_last        = r_last;
        o_cmd         = '0;
        o_cmd.waddr   = r_idx;
        o_cmd.raddr   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == lcs_pkg::KIND_X) begin
                        o_cmd.store_x = 1'b1;
                    end else begin
                        o_cmd.start_y = 1'b1;
                        if (i_stat.x_count == '0) begin
                            // No stored X: the row is empty and the result is zero.
                            o_cmd.emit = i_last;
                        end else begin
                            n_state = ST_RUN;
                            n_idx   = '0;
                            n_last  = i_last;
                        end
                    end
                end
            end
            ST_RUN: begin
                o_cmd.step  = 1'b1;
                o_cmd.raddr = lcs_pkg::ADDR_BITS'(r_idx + 1'b1);
                n_idx       = lcs_pkg::ADDR_BITS'(r_idx + 1'b1);
                if (row_end) begin
                    o_cmd.emit = r_last;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_last  <= n_last;
        end
    end

`ifndef SYNTH
    // A row pass only runs over a non-empty X.
    a_run_has_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (i_stat.x_count != '0))
        else $error("row pass with empty X store");

    // Every column stepped lies inside the stored X.
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> ({1'b0, r_idx} < i_stat.x_count))
        else $error("column index beyond stored X");

    // A result ends the work on the item.
    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == ST_IDLE))
        else $error("still busy after result");

    // X storage and Y start never coincide.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.store_x && (o_cmd.start_y || o_cmd.step)))
        else $error("conflicting commands");
`endif

endmodule

`default_nettype wire

@@ rtl/lcs_dpath.sv @@
`default_nettype none

module lcs_dpath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lcs_pkg::t_cmd                i_cmd,
    input  wire logic [7:0]                   i_symbol,
    output lcs_pkg::t_stat                    o_stat,
    output logic                              o_valid,
    output logic [lcs_pkg::LEN_BITS-1:0]      o_lcs_length,
    output logic                              o_x_overflow
);

    // Symbol and row memories.
    logic [lcs_pkg::SYMBOL_BITS-1:0] r_x_mem   [lcs_pkg::MAX_LEN];
    logic [lcs_pkg::LEN_BITS-1:0]    r_row_mem [lcs_pkg::MAX_LEN];
    logic [lcs_pkg::SYMBOL_BITS-1:0] r_x_rd;
    logic [lcs_pkg::LEN_BITS-1:0]    r_row_rd;

    // Pair state.
    logic [lcs_pkg::CNT_BITS-1:0]    r_x_count, n_x_count;
    logic                            r_ovf, n_ovf;
    logic                            r_in_y, n_in_y;
    logic                            r_first_row;
    logic [lcs_pkg::SYMBOL_BITS-1:0] r_y_sym;
    logic [lcs_pkg::LEN_BITS-1:0]    r_diag;
    logic [lcs_pkg::LEN_BITS-1:0]    r_left;

    // Output registers.
    logic                            r_valid;
    logic [lcs_pkg::LEN_BITS-1:0]    r_len;
    logic                            r_ovf_out;

    logic [lcs_pkg::SYMBOL_BITS-1:0] sym;
    logic [lcs_pkg::ADDR_BITS-1:0]   x_waddr;
    logic                            x_full;
    logic                            x_write;
    logic [lcs_pkg::LEN_BITS-1:0]    up;
    logic [lcs_pkg::LEN_BITS-1:0]    dp_val;

    assign sym     = i_symbol[lcs_pkg::SYMBOL_BITS-1:0];
    assign x_full  = !r_in_y && (r_x_count == lcs_pkg::CNT_BITS'(lcs_pkg::MAX_LEN));
    assign x_waddr = r_in_y ? '0 : r_x_count[lcs_pkg::ADDR_BITS-1:0];
    assign x_write = i_cmd.store_x && !x_full;

    // One table entry: the row is taken as zero on the first Y symbol.
    assign up     = r_first_row ? '0 : r_row_rd;
    assign dp_val = (r_x_rd == r_y_sym) ? lcs_pkg::LEN_BITS'(r_diag + 1'b1)
                                        : ((up > r_left) ? up : r_left);

    // Memory ports: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (x_write) begin
            r_x_mem[x_waddr] <= sym;
        end
        if (i_cmd.step) begin
            r_row_mem[i_cmd.waddr] <= dp_val;
        end
        r_x_rd   <= r_x_mem[i_cmd.raddr];
        r_row_rd <= r_row_mem[i_cmd.raddr];
    end

    // Next pair state: an X symbol during Y abandons the pair, a result ends it.
    always_comb begin
        n_x_count = r_x_count;
        n_ovf     = r_ovf;
        n_in_y    = r_in_y;
        priority if (i_cmd.emit) begin
            n_x_count = '0;
            n_ovf     = 1'b0;
            n_in_y    = 1'b0;
        end else if (i_cmd.store_x) begin
            if (r_in_y) begin
                n_x_count = lcs_pkg::CNT_BITS'(1);
                n_ovf     = 1'b0;
                n_in_y    = 1'b0;
            end else if (x_full) begin
                n_ovf = 1'b1;
            end else begin
                n_x_count = lcs_pkg::CNT_BITS'(r_x_count + 1'b1);
            end
        end else if (i_cmd.start_y) begin
            n_in_y = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_count <= '0;
            r_ovf     <= 1'b0;
            r_in_y    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_x_count <= n_x_count;
            r_ovf     <= n_ovf;
            r_in_y    <= n_in_y;
            r_valid   <= i_cmd.emit;
        end
    end

    // Row pass registers and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_y) begin
            r_y_sym     <= sym;
            r_first_row <= !r_in_y;
            r_diag      <= '0;
            r_left      <= '0;
        end else if (i_cmd.step) begin
            r_diag <= up;
            r_left <= dp_val;
        end
        if (i_cmd.emit) begin
            r_len     <= i_cmd.step ? dp_val : '0;
            r_ovf_out <= r_ovf;
        end
    end

    assign o_stat.x_count = r_x_count;
    assign o_valid        = r_valid;
    assign o_lcs_length   = r_len;
    assign o_x_overflow   = r_ovf_out;

endmodule

`default_nettype wire
